>>> design/mvna_pkg.sv
// Shared codes and field widths for the mesh vertex normal accumulator.
package mvna_pkg;
   localparam int IndexWidth  = 10;
   localparam int PosWidth    = 24;
   localparam int NormalWidth = 16;

   typedef enum logic [1:0] {
      FUNC_WRITE    = 2'd0,
      FUNC_TRIANGLE = 2'd1,
      FUNC_READ     = 2'd2,
      FUNC_UNUSED   = 2'd3
   } func_type;
endpackage

>>> design/mvna_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mvna_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> design/mesh_vertex_normal_accumulator.sv
// Top level: vertex position and normal-sum stores with a sequenced normaliser.
//
// One word is taken at a time; req_stall is high until it is finished. A write
// never raises req_stall. A triangle fetches its corners and forms edges, runs
// the cross product on one shared multiplier, then loads and aligns the vector
// (a shift of up to 29 bits, one bit a cycle), sums the squares, takes a
// bit-serial square root, does three 15-step divisions and finally the three
// read-modify-writes of the normal-sum store. A read loads the vertex's normal
// sum and normalises it on the same path; its result sits in an output
// register, so the next word is taken while it waits. Zero-length vectors skip
// the normaliser. Both stores are single-port-write RAMs with registered reads.
module mesh_vertex_normal_accumulator #(
   parameter int MAX_VERTICES = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_func,
   input  logic [mvna_pkg::IndexWidth-1:0]      req_index_a,
   input  logic [mvna_pkg::IndexWidth-1:0]      req_index_b,
   input  logic [mvna_pkg::IndexWidth-1:0]      req_index_c,
   input  logic signed [mvna_pkg::PosWidth-1:0] req_pos_x,
   input  logic signed [mvna_pkg::PosWidth-1:0] req_pos_y,
   input  logic signed [mvna_pkg::PosWidth-1:0] req_pos_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mvna_pkg::IndexWidth-1:0]      rsp_vertex_index,
   output logic signed [mvna_pkg::NormalWidth-1:0] rsp_normal_x,
   output logic signed [mvna_pkg::NormalWidth-1:0] rsp_normal_y,
   output logic signed [mvna_pkg::NormalWidth-1:0] rsp_normal_z,
   output logic                                 rsp_degenerate
);
   import mvna_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int IW = (AW > IndexWidth) ? AW : IndexWidth;
   localparam int SW = 3 * PosWidth;

   typedef enum logic [4:0] {
      S_IDLE, S_PA, S_PB, S_PC, S_PW, S_EDGE, S_CROSS, S_NLOAD, S_SHIFT,
      S_SQ, S_SQRT, S_DINIT, S_DIV, S_FIN, S_ACC_RD, S_ACC_WR, S_R_RD,
      S_R_LD, S_OUT
   } state_type;

   function automatic logic [AW-1:0] to_addr(input logic [IndexWidth-1:0] idx);
      logic [IW-1:0] w;
      w = IW'(idx);
      return w[AW-1:0];
   endfunction

   state_type                 state_ff;
   logic [1:0]                func_ff;
   logic [IndexWidth-1:0]     ia_ff, ib_ff, ic_ff;
   logic signed [23:0]        pa_ff [3];
   logic signed [23:0]        pb_ff [3];
   logic signed [23:0]        pc_ff [3];
   logic signed [24:0]        e1_ff [3];
   logic signed [24:0]        e2_ff [3];
   logic signed [50:0]        vec_ff [3];
   logic signed [49:0]        prod_ff;
   logic [2:0]                step_ff;
   logic [50:0]               mag_ff [3];
   logic                      neg_ff [3];
   logic [50:0]               big_ff;
   logic [59:0]               sqp_ff;
   logic [61:0]               ssum_ff;
   logic [61:0]               n_ff;
   logic [63:0]               r_ff, rbit_ff;
   logic [31:0]               len_ff;
   logic [45:0]               rem_ff, dvs_ff;
   logic [14:0]               q_ff;
   logic [3:0]                cnt_ff;
   logic [1:0]                comp_ff, k_ff;
   logic signed [15:0]        fn_ff [3];
   logic                      deg_ff;
   logic                      rsp_valid_ff;
   logic [IndexWidth-1:0]     rsp_index_ff;
   logic signed [15:0]        rsp_nx_ff, rsp_ny_ff, rsp_nz_ff;
   logic                      rsp_deg_ff;

   logic                      accept, ok_a, ok_b, ok_c;
   logic                      pos_we, sum_we;
   logic [AW-1:0]             pos_raddr, sum_raddr, sum_waddr, corner_addr;
   logic [SW-1:0]             pos_rdata, sum_rdata, sum_wdata, sat_data;
   logic signed [24:0]        op_a, op_b;
   logic [1:0]                cj;
   logic [50:0]               absv [3];
   logic [50:0]               maxv;
   logic [29:0]               sq_op;
   logic [63:0]               sq_t, r_next;
   logic                      sq_ge, div_ge;
   logic [14:0]               q_next;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign ok_a      = 32'(req_index_a) < MAX_VERTICES;
   assign ok_b      = 32'(req_index_b) < MAX_VERTICES;
   assign ok_c      = 32'(req_index_c) < MAX_VERTICES;

   always_comb begin
      case (k_ff)
         2'd0:    corner_addr = to_addr(ia_ff);
         2'd1:    corner_addr = to_addr(ib_ff);
         default: corner_addr = to_addr(ic_ff);
      endcase
      case (state_ff)
         S_PA:    pos_raddr = to_addr(ia_ff);
         S_PB:    pos_raddr = to_addr(ib_ff);
         default: pos_raddr = to_addr(ic_ff);
      endcase
      sum_raddr = (state_ff == S_ACC_RD) ? corner_addr : to_addr(ia_ff);
   end

   assign pos_we    = accept && (req_func == FUNC_WRITE) && ok_a;
   assign sum_we    = pos_we || (state_ff == S_ACC_WR);
   assign sum_waddr = (state_ff == S_ACC_WR) ? corner_addr : to_addr(req_index_a);
   assign sum_wdata = (state_ff == S_ACC_WR) ? sat_data : '0;

   always_comb begin
      logic signed [24:0] s;
      for (int i = 0; i < 3; i++) begin
         s = 25'($signed(sum_rdata[i*PosWidth +: PosWidth])) + 25'(fn_ff[i]);
         if (s > 25'sd8388607) begin
            sat_data[i*PosWidth +: PosWidth] = 24'h7fffff;
         end else if (s < -25'sd8388608) begin
            sat_data[i*PosWidth +: PosWidth] = 24'h800000;
         end else begin
            sat_data[i*PosWidth +: PosWidth] = s[23:0];
         end
      end
   end

   always_comb begin
      case (step_ff)
         3'd0:    begin op_a = e1_ff[1]; op_b = e2_ff[2]; end
         3'd1:    begin op_a = e1_ff[2]; op_b = e2_ff[1]; end
         3'd2:    begin op_a = e1_ff[2]; op_b = e2_ff[0]; end
         3'd3:    begin op_a = e1_ff[0]; op_b = e2_ff[2]; end
         3'd4:    begin op_a = e1_ff[0]; op_b = e2_ff[1]; end
         default: begin op_a = e1_ff[1]; op_b = e2_ff[0]; end
      endcase
      cj = 2'((step_ff - 3'd1) >> 1);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         absv[i] = vec_ff[i][50] ? 51'(-vec_ff[i]) : 51'(vec_ff[i]);
      end
      maxv = absv[0];
      if (absv[1] > maxv) maxv = absv[1];
      if (absv[2] > maxv) maxv = absv[2];
   end

   always_comb begin
      case (step_ff)
         3'd0:    sq_op = mag_ff[0][29:0];
         3'd1:    sq_op = mag_ff[1][29:0];
         default: sq_op = mag_ff[2][29:0];
      endcase
      sq_t   = r_ff + rbit_ff;
      sq_ge  = {2'b00, n_ff} >= sq_t;
      r_next = sq_ge ? ((r_ff >> 1) + rbit_ff) : (r_ff >> 1);
      div_ge = rem_ff >= dvs_ff;
      q_next = {q_ff[13:0], div_ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_OUT && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  func_ff <= req_func;
                  ia_ff   <= req_index_a;
                  ib_ff   <= req_index_b;
                  ic_ff   <= req_index_c;
                  case (req_func)
                     FUNC_TRIANGLE: begin
                        if (ok_a && ok_b && ok_c) state_ff <= S_PA;
                     end
                     FUNC_READ: begin
                        if (ok_a) begin
                           state_ff <= S_R_RD;
                        end else begin
                           for (int i = 0; i < 3; i++) fn_ff[i] <= '0;
                           deg_ff   <= 1'b1;
                           state_ff <= S_OUT;
                        end
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_PA: state_ff <= S_PB;
            S_PB: begin
               for (int i = 0; i < 3; i++) pa_ff[i] <= pos_rdata[i*PosWidth +: PosWidth];
               state_ff <= S_PC;
            end
            S_PC: begin
               for (int i = 0; i < 3; i++) pb_ff[i] <= pos_rdata[i*PosWidth +: PosWidth];
               state_ff <= S_PW;
            end
            S_PW: begin
               for (int i = 0; i < 3; i++) pc_ff[i] <= pos_rdata[i*PosWidth +: PosWidth];
               state_ff <= S_EDGE;
            end
            S_EDGE: begin
               for (int i = 0; i < 3; i++) begin
                  e1_ff[i] <= 25'(pb_ff[i]) - 25'(pa_ff[i]);
                  e2_ff[i] <= 25'(pc_ff[i]) - 25'(pa_ff[i]);
               end
               step_ff  <= '0;
               state_ff <= S_CROSS;
            end
            S_CROSS: begin
               if (step_ff != 3'd6) prod_ff <= op_a * op_b;
               if (step_ff != 3'd0) begin
                  if (!step_ff[0]) vec_ff[cj] <= vec_ff[cj] - 51'(prod_ff);
                  else             vec_ff[cj] <= 51'(prod_ff);
               end
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd6) state_ff <= S_NLOAD;
            end
            S_NLOAD: begin
               if (maxv == '0) begin
                  for (int i = 0; i < 3; i++) fn_ff[i] <= '0;
                  deg_ff   <= 1'b1;
                  state_ff <= S_FIN;
               end else begin
                  for (int i = 0; i < 3; i++) begin
                     mag_ff[i] <= absv[i];
                     neg_ff[i] <= vec_ff[i][50];
                  end
                  big_ff   <= maxv;
                  deg_ff   <= 1'b0;
                  state_ff <= S_SHIFT;
               end
            end
            S_SHIFT: begin
               if (big_ff[50:30] != '0) begin
                  for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 1;
                  big_ff <= big_ff >> 1;
               end else if (!big_ff[29]) begin
                  for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] << 1;
                  big_ff <= big_ff << 1;
               end else begin
                  step_ff  <= '0;
                  ssum_ff  <= '0;
                  state_ff <= S_SQ;
               end
            end
            S_SQ: begin
               if (step_ff != 3'd3) sqp_ff <= sq_op * sq_op;
               if (step_ff != 3'd0) ssum_ff <= ssum_ff + 62'(sqp_ff);
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd3) begin
                  n_ff     <= ssum_ff + 62'(sqp_ff);
                  r_ff     <= '0;
                  rbit_ff  <= 64'd1 << 62;
                  state_ff <= S_SQRT;
               end
            end
            S_SQRT: begin
               if (sq_ge) n_ff <= n_ff - sq_t[61:0];
               r_ff    <= r_next;
               rbit_ff <= rbit_ff >> 2;
               if (rbit_ff[0]) begin
                  len_ff   <= r_next[31:0];
                  comp_ff  <= '0;
                  state_ff <= S_DINIT;
               end
            end
            S_DINIT: begin
               rem_ff   <= (46'(mag_ff[comp_ff][29:0]) << 14) + 46'(len_ff[31:1]);
               dvs_ff   <= 46'(len_ff) << 14;
               q_ff     <= '0;
               cnt_ff   <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_ge) rem_ff <= rem_ff - dvs_ff;
               q_ff   <= q_next;
               dvs_ff <= dvs_ff >> 1;
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'd14) begin
                  fn_ff[comp_ff] <= neg_ff[comp_ff] ? -16'(q_next) : 16'(q_next);
                  comp_ff        <= comp_ff + 2'd1;
                  state_ff       <= (comp_ff == 2'd2) ? S_FIN : S_DINIT;
               end
            end
            S_FIN: begin
               k_ff     <= '0;
               state_ff <= (func_ff == FUNC_TRIANGLE) ? S_ACC_RD : S_OUT;
            end
            S_ACC_RD: state_ff <= S_ACC_WR;
            S_ACC_WR: begin
               k_ff     <= k_ff + 2'd1;
               state_ff <= (k_ff == 2'd2) ? S_IDLE : S_ACC_RD;
            end
            S_R_RD: state_ff <= S_R_LD;
            S_R_LD: begin
               for (int i = 0; i < 3; i++) begin
                  vec_ff[i] <= 51'($signed(sum_rdata[i*PosWidth +: PosWidth]));
               end
               state_ff <= S_NLOAD;
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_index_ff <= ia_ff;
                  rsp_nx_ff    <= fn_ff[0];
                  rsp_ny_ff    <= fn_ff[1];
                  rsp_nz_ff    <= fn_ff[2];
                  rsp_deg_ff   <= deg_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   mvna_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_we),
      .wr_addr (to_addr(req_index_a)),
      .wr_data ({req_pos_z, req_pos_y, req_pos_x}),
      .rd_addr (pos_raddr),
      .rd_data (pos_rdata)
   );

   mvna_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_sum_ram (
      .clock   (clock),
      .wr_en   (sum_we),
      .wr_addr (sum_waddr),
      .wr_data (sum_wdata),
      .rd_addr (sum_raddr),
      .rd_data (sum_rdata)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_index = rsp_index_ff;
   assign rsp_normal_x     = rsp_nx_ff;
   assign rsp_normal_y     = rsp_ny_ff;
   assign rsp_normal_z     = rsp_nz_ff;
   assign rsp_degenerate   = rsp_deg_ff;

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("response raised outside output state");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      sum_we |-> !(state_ff == S_ACC_RD || state_ff == S_R_RD))
      else $error("normal-sum read and write in the same cycle");

   a_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQ) |-> (big_ff[50:30] == '0 && big_ff[29]))
      else $error("alignment shift left magnitude out of range");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_nx_ff <= 16'sd16384 && rsp_nx_ff >= -16'sd16384 &&
                        rsp_ny_ff <= 16'sd16384 && rsp_ny_ff >= -16'sd16384 &&
                        rsp_nz_ff <= 16'sd16384 && rsp_nz_ff >= -16'sd16384))
      else $error("normal component outside unit range");
endmodule
